FILE: design/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// shared constants and arctangent table of the waypoint path follower
// ----------------------------------------------------------------------------
package wpf_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_POSE  = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_ACCEPTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [2:0] REG_MAX_V  = 3'd0;
  localparam logic [2:0] REG_MAX_W  = 3'd1;
  localparam logic [2:0] REG_SLOW_W = 3'd2;
  localparam logic [2:0] REG_REACH  = 3'd3;
  localparam logic [2:0] REG_WINDOW = 3'd4;

  localparam int TabLen = 24;

  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/wpf_ram.sv
// ----------------------------------------------------------------------------
// wpf_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module wpf_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: design/wpf_cordic.sv
// ----------------------------------------------------------------------------
// wpf_cordic
// iterative vectoring cordic, one micro-rotation per cycle, 16-bit bearing
// ----------------------------------------------------------------------------
module wpf_cordic #(
  parameter int Steps = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [24:0] dx_i,
  input  logic [24:0] dy_i,
  output logic        done_o,
  output logic [15:0] bearing_o
);

  localparam int SW = (Steps > wpf_pkg::TabLen) ? wpf_pkg::TabLen : Steps;
  localparam int CW = $clog2(SW + 1);
  // magnitude growth stays below 1.65 times sqrt(2) times 2^25
  localparam int XW = 28;

  logic signed [XW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic [31:0] ang_q, ang_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic run_q, run_d, done_q, done_d;
  logic signed [XW-1:0] dxe, dye;

  assign dxe = XW'($signed(dx_i));
  assign dye = XW'($signed(dy_i));
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    ang_d = ang_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = 1'b0;
    if (start_i) begin
      if (dxe < 0) begin
        x_d = -dxe;
        y_d = -dye;
        ang_d = 32'h8000_0000;
      end else begin
        x_d = dxe;
        y_d = dye;
        ang_d = '0;
      end
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        ang_d = ang_q + wpf_pkg::atan_tab(5'(cnt_q));
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        ang_d = ang_q - wpf_pkg::atan_tab(5'(cnt_q));
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(SW - 1)) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    ang_q <= ang_d;
  end

  logic [31:0] rnd;
  assign rnd = ang_q + 32'h0000_8000;
  assign done_o = done_q;
  assign bearing_o = rnd[31:16];

endmodule

FILE: design/waypoint_path_follower.sv
// ----------------------------------------------------------------------------
// waypoint_path_follower
// waypoint stack in ram, pop-on-reach and cordic steering toward the top
// ----------------------------------------------------------------------------
// clear, push, stop: result valid the cycle after the transaction
// pose update: per checked waypoint the states read, difference, squares and compare run in turn,
//   then an empty stack gives the finished result, else the cordic bearing feeds the command
// one item at a time; the input is taken again once the result register is free
// reset clears the stack count, last command and registers to defaults; the
//   ram holds no reset value
module waypoint_path_follower #(
  parameter int PathDepth   = 64,
  parameter int CordicSteps = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], pos_x[25:2], pos_y[49:26], heading[65:50], zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], cmd_sent[2], speed_cmd[22:3], turn_cmd[44:23],
  // path_changed[45], zero pad
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [20:0] cfg_data_i
);

  localparam int AW = (PathDepth > 1) ? $clog2(PathDepth) : 1;
  localparam int NW = $clog2(PathDepth + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIST = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_CORD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;

  logic [19:0] max_v_q;
  logic [20:0] max_w_q, slow_w_q;
  logic [15:0] reach_q;
  logic [14:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_v_q <= 20'd45000;
      max_w_q <= 21'd600000;
      slow_w_q <= 21'd180000;
      reach_q <= 16'd655;
      window_q <= 15'd5461;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wpf_pkg::REG_MAX_V:  max_v_q <= cfg_data_i[19:0];
        wpf_pkg::REG_MAX_W:  max_w_q <= cfg_data_i;
        wpf_pkg::REG_SLOW_W: slow_w_q <= cfg_data_i;
        wpf_pkg::REG_REACH:  reach_q <= cfg_data_i[15:0];
        wpf_pkg::REG_WINDOW: window_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic [2:0] st_q, st_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [19:0] lspd_q, lspd_d;
  logic [21:0] lturn_q, lturn_d;
  logic ov_q, ov_d;
  logic [47:0] od_q, od_d;
  logic chg_q, chg_d;
  logic signed [23:0] px_q, py_q;
  logic [15:0] head_q;
  logic [23:0] px_d, py_d;
  logic [15:0] head_d;
  logic signed [24:0] dx_q, dy_q, dx_d, dy_d;
  logic [49:0] sqx_q, sqy_q, sqx_d, sqy_d;
  logic [31:0] r2_q;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [47:0] ram_rd;
  logic cord_start, cord_done;
  logic [15:0] bearing;

  wpf_ram #(.Width(48), .Depth(PathDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(s_axis_tdata[49:2]),
    .rdata_o(ram_rd)
  );

  wpf_cordic #(.Steps(CordicSteps)) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cord_start),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .done_o   (cord_done),
    .bearing_o(bearing)
  );

  logic in_fire;
  logic [1:0] op;
  logic [NW-1:0] top;
  logic [50:0] d2;
  logic [15:0] diff;
  logic [15:0] mag;
  logic [19:0] nv;
  logic [21:0] nw;

  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign op = s_axis_tdata[1:0];
  assign top = cnt_q - 1'b1;
  assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign diff = bearing - head_q;
  assign mag = diff[15] ? (~diff + 1'b1) : diff;

  always_comb begin
    if (mag < {1'b0, window_q}) begin
      nv = max_v_q;
      nw = (!diff[15] && diff != 16'd0) ? {1'b0, slow_w_q} : -{1'b0, slow_w_q};
    end else begin
      nv = '0;
      nw = (!diff[15] && diff != 16'd0) ? {1'b0, max_w_q} : -{1'b0, max_w_q};
    end
  end

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    lspd_d = lspd_q;
    lturn_d = lturn_q;
    ov_d = ov_q;
    od_d = od_q;
    chg_d = chg_q;
    px_d = px_q;
    py_d = py_q;
    head_d = head_q;
    dx_d = dx_q;
    dy_d = dy_q;
    sqx_d = sqx_q;
    sqy_d = sqy_q;
    ram_we = 1'b0;
    ram_addr = AW'(top);
    cord_start = 1'b0;
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          px_d = s_axis_tdata[25:2];
          py_d = s_axis_tdata[49:26];
          head_d = s_axis_tdata[65:50];
          chg_d = 1'b0;
          case (op)
            wpf_pkg::OP_CLEAR: begin
              cnt_d = '0;
              od_d = {2'b0, 1'b1, lturn_q, lspd_q, 1'b0, wpf_pkg::ST_ACCEPTED};
              ov_d = 1'b1;
            end
            wpf_pkg::OP_PUSH: begin
              if (cnt_q < NW'(PathDepth)) begin
                ram_we = 1'b1;
                ram_addr = AW'(cnt_q);
                cnt_d = cnt_q + 1'b1;
                od_d = {2'b0, 1'b1, lturn_q, lspd_q, 1'b0, wpf_pkg::ST_ACCEPTED};
              end else begin
                od_d = {2'b0, 1'b0, lturn_q, lspd_q, 1'b0, wpf_pkg::ST_FULL};
              end
              ov_d = 1'b1;
            end
            wpf_pkg::OP_STOP: begin
              lspd_d = '0;
              lturn_d = '0;
              od_d = {2'b0, 1'b0, 22'd0, 20'd0,
                      (lspd_q != '0 || lturn_q != '0), wpf_pkg::ST_ACCEPTED};
              ov_d = 1'b1;
            end
            default: st_d = S_READ;
          endcase
        end
      end
      S_READ: begin
        if (cnt_q == '0) begin
          lspd_d = '0;
          lturn_d = '0;
          od_d = {2'b0, chg_q, 22'd0, 20'd0,
                  (lspd_q != '0 || lturn_q != '0), wpf_pkg::ST_FINISHED};
          ov_d = 1'b1;
          st_d = S_IDLE;
        end else begin
          st_d = S_DIST;
        end
      end
      S_DIST: begin
        dx_d = $signed({ram_rd[23], ram_rd[23:0]}) - $signed({px_q[23], px_q});
        dy_d = $signed({ram_rd[47], ram_rd[47:24]}) - $signed({py_q[23], py_q});
        st_d = S_CHK;
      end
      S_CHK: begin
        sqx_d = 50'($signed(dx_q) * $signed(dx_q));
        sqy_d = 50'($signed(dy_q) * $signed(dy_q));
        st_d = S_CMP;
      end
      S_CMP: begin
        if (d2 < {19'd0, r2_q}) begin
          cnt_d = cnt_q - 1'b1;
          chg_d = 1'b1;
          st_d = S_READ;
        end else begin
          cord_start = 1'b1;
          st_d = S_CORD;
        end
      end
      S_CORD: begin
        if (cord_done) begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        lspd_d = nv;
        lturn_d = nw;
        od_d = {2'b0, chg_q, nw, nv, (nv != lspd_q || nw != lturn_q), wpf_pkg::ST_BUSY};
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      lspd_q <= '0;
      lturn_q <= '0;
      ov_q <= 1'b0;
      chg_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      lspd_q <= lspd_d;
      lturn_q <= lturn_d;
      ov_q <= ov_d;
      chg_q <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    px_q <= px_d;
    py_q <= py_d;
    head_q <= head_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    r2_q <= reach_q * reach_q;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;

endmodule

FILE: design/wpf_checker.sv
// ----------------------------------------------------------------------------
// wpf_checker
// port-level checks of the waypoint path follower
// ----------------------------------------------------------------------------
module wpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken with result pending");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == wpf_pkg::OP_STOP
    |=> m_axis_tvalid && m_axis_tdata[44:3] == 42'd0)
    else $error("stop did not zero command");

  a_full_nochange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == wpf_pkg::ST_FULL |-> !m_axis_tdata[45])
    else $error("full push flagged path change");

endmodule

bind waypoint_path_follower wpf_checker u_wpf_checker (.*);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking test of the waypoint path follower: a directed table, then
// random push/pose/clear/stop sequences under random stalls, with a long
// output hold-off, each result checked against a behavioral steering
// predictor or, for flagged table rows, against a literal expectation
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;
  localparam int Steps = 16;
  localparam int RandItems = 900;
  localparam longint CycleLimit = 1500000;

  typedef struct packed {
    logic [1:0]  status;
    logic        sent;
    logic [19:0] speed;
    logic [21:0] turn;
    logic        changed;
  } steer_t;

  typedef struct {
    logic [1:0]  op;
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] hd;
    logic        chk;
    steer_t      want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = wpf_pkg::REG_MAX_V;
  logic [20:0] cfg_data_i = '0;

  waypoint_path_follower dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [19:0] p_max_v = 20'd45000;
  logic [20:0] p_max_w = 21'd600000;
  logic [20:0] p_slow_w = 21'd180000;
  logic [15:0] p_reach = 16'd655;
  logic [14:0] p_window = 15'd5461;
  logic signed [23:0] wp_x [Depth];
  logic signed [23:0] wp_y [Depth];
  int          wp_count = 0;
  logic [19:0] cur_speed = '0;
  logic signed [21:0] cur_turn = '0;

  steer_t pending [$];
  steer_t literal [$];
  logic   has_lit [$];
  int     errors = 0;
  longint cycles = 0;
  logic   sending_done = 1'b0;
  logic   hold_off = 1'b0;

  function automatic logic [15:0] bearing(input longint x0, input longint y0);
    longint x, y, xs, ys;
    logic [31:0] ang;
    x = x0; y = y0; ang = 0;
    if (x < 0) begin
      x = -x; y = -y; ang = 32'h8000_0000;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; ang = ang + wpf_pkg::atan_tab(i[4:0]);
      end else begin
        x = x - ys; y = y + xs; ang = ang - wpf_pkg::atan_tab(i[4:0]);
      end
    end
    ang = ang + 32'h8000;
    return ang[31:16];
  endfunction

  function automatic logic apply_cmd(input logic [19:0] v, input logic signed [21:0] w);
    if (v != cur_speed || w != cur_turn) begin
      cur_speed = v; cur_turn = w;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic steer_t predict_steer(input logic [1:0] op, input logic signed [23:0] px,
                                           input logic signed [23:0] py, input logic [15:0] hd);
    steer_t r;
    longint dx, dy, r2;
    logic [15:0] b, d16;
    int diff, mag;
    logic [19:0] v;
    logic signed [21:0] w;
    r = '0;
    r.status = wpf_pkg::ST_ACCEPTED;
    case (op)
      wpf_pkg::OP_CLEAR: begin
        wp_count = 0; r.changed = 1'b1;
      end
      wpf_pkg::OP_PUSH: begin
        if (wp_count < Depth) begin
          wp_x[wp_count] = px; wp_y[wp_count] = py;
          wp_count++; r.changed = 1'b1;
        end else r.status = wpf_pkg::ST_FULL;
      end
      wpf_pkg::OP_STOP: r.sent = apply_cmd('0, '0);
      default: begin
        r2 = longint'(p_reach) * longint'(p_reach);
        while (wp_count > 0) begin
          dx = longint'(wp_x[wp_count-1]) - longint'(px);
          dy = longint'(wp_y[wp_count-1]) - longint'(py);
          if (dx * dx + dy * dy >= r2) break;
          wp_count--; r.changed = 1'b1;
        end
        if (wp_count == 0) begin
          r.sent = apply_cmd('0, '0); r.status = wpf_pkg::ST_FINISHED;
        end else begin
          dx = longint'(wp_x[wp_count-1]) - longint'(px);
          dy = longint'(wp_y[wp_count-1]) - longint'(py);
          b = bearing(dx, dy);
          d16 = b - hd;
          diff = int'($signed(d16));
          mag = diff < 0 ? -diff : diff;
          if (mag < int'(p_window)) begin
            v = p_max_v;
            w = diff > 0 ? $signed({1'b0, p_slow_w}) : -$signed({1'b0, p_slow_w});
          end else begin
            v = '0;
            w = diff > 0 ? $signed({1'b0, p_max_w}) : -$signed({1'b0, p_max_w});
          end
          r.sent = apply_cmd(v, w); r.status = wpf_pkg::ST_BUSY;
        end
      end
    endcase
    r.speed = cur_speed;
    r.turn = cur_turn;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      wpf_pkg::REG_MAX_V:  p_max_v = val[19:0];
      wpf_pkg::REG_MAX_W:  p_max_w = val;
      wpf_pkg::REG_SLOW_W: p_slow_w = val;
      wpf_pkg::REG_REACH:  p_reach = val[15:0];
      wpf_pkg::REG_WINDOW: p_window = val[14:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // offer one transaction; the falling edge after acceptance is the next drive point
  task automatic send_item(input logic [1:0] op, input logic [23:0] px, input logic [23:0] py,
                           input logic [15:0] hd, input logic chk, input steer_t want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    repeat (gap) @(negedge clk_i);
    s_axis_tdata = {6'd0, hd, py, px, op};
    s_axis_tvalid = 1'b1;
    pending.insert(pending.size(), predict_steer(op, px, py, hd));
    literal.insert(literal.size(), want);
    has_lit.insert(has_lit.size(), chk);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic rand_item(input int bias);
    logic [1:0] op;
    logic [23:0] px, py;
    int k;
    op = wpf_pkg::OP_POSE;
    k = $urandom_range(0, 99);
    if (k < 30) op = wpf_pkg::OP_PUSH;
    else if (k < 34) op = wpf_pkg::OP_CLEAR;
    else if (k < 37) op = wpf_pkg::OP_STOP;
    px = $urandom; py = $urandom;
    if (wp_count > 0 && op == wpf_pkg::OP_POSE && $urandom_range(0, 2) == 0) begin
      // land near the top waypoint so it can get popped
      px = wp_x[wp_count-1] + 24'($signed(5'($urandom)) * bias);
      py = wp_y[wp_count-1] + 24'($signed(5'($urandom)) * bias);
    end else if ($urandom_range(0, 1) == 0) begin
      px = {{8{px[15]}}, px[15:0]};
      py = {{8{py[15]}}, py[15:0]};
    end
    send_item(op, px, py, 16'($urandom), 1'b0, '0);
  endtask

  initial begin
    row_t tbl [$];
    steer_t z;
    z = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // after reset: empty stack, stop, clear
    tbl.insert(tbl.size(), '{wpf_pkg::OP_POSE, 24'h7fffff, 24'h800000, 16'h8000, 1'b1,
                             '{wpf_pkg::ST_FINISHED, 1'b0, 20'd0, 22'd0, 1'b0}});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_STOP, 24'hffffff, 24'h0, 16'hffff, 1'b1,
                             '{wpf_pkg::ST_ACCEPTED, 1'b0, 20'd0, 22'd0, 1'b0}});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_CLEAR, 24'h0, 24'hffffff, 16'h0, 1'b1,
                             '{wpf_pkg::ST_ACCEPTED, 1'b0, 20'd0, 22'd0, 1'b1}});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_PUSH, 24'h800000, 24'h7fffff, 16'h0, 1'b1,
                             '{wpf_pkg::ST_ACCEPTED, 1'b0, 20'd0, 22'd0, 1'b1}});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_PUSH, 24'h7fffff, 24'h800000, 16'h0, 1'b0, z});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_POSE, 24'h800000, 24'h7fffff, 16'h7fff, 1'b0, z});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_POSE, 24'h0, 24'h0, 16'h8000, 1'b0, z});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_POSE, 24'h0, 24'h0, 16'h0, 1'b0, z});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_STOP, 24'h0, 24'h0, 16'h0, 1'b0, z});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_POSE, 24'h7fffff, 24'h800000, 16'h0, 1'b0, z});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_POSE, 24'h7fffff, 24'h800000, 16'h0, 1'b0, z});
    tbl.insert(tbl.size(), '{wpf_pkg::OP_CLEAR, 24'h0, 24'h0, 16'h0, 1'b0, z});
    foreach (tbl[i]) send_item(tbl[i].op, tbl[i].px, tbl[i].py, tbl[i].hd,
                               tbl[i].chk, tbl[i].want);
    // fill to the limit and overflow
    for (int i = 0; i < Depth + 2; i++) rand_item(0);
    for (int i = 0; i < Depth + 2; i++) send_item(wpf_pkg::OP_PUSH, 24'($urandom),
                                                  24'($urandom), 16'($urandom), 1'b0, z);
    drain();
    // zero reach: robot on the waypoint, zero window
    write_reg(wpf_pkg::REG_REACH, 21'd0);
    write_reg(wpf_pkg::REG_WINDOW, 21'd0);
    send_item(wpf_pkg::OP_CLEAR, 24'h0, 24'h0, 16'h0, 1'b0, z);
    send_item(wpf_pkg::OP_PUSH, 24'h1234, 24'h5678, 16'h0, 1'b0, z);
    send_item(wpf_pkg::OP_POSE, 24'h1234, 24'h5678, 16'h0, 1'b0, z);
    send_item(wpf_pkg::OP_POSE, 24'h1234, 24'h5678, 16'hc000, 1'b0, z);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(wpf_pkg::REG_MAX_V, 21'd45000);
          write_reg(wpf_pkg::REG_MAX_W, 21'd600000);
          write_reg(wpf_pkg::REG_SLOW_W, 21'd180000);
          write_reg(wpf_pkg::REG_REACH, 21'd655);
          write_reg(wpf_pkg::REG_WINDOW, 21'd5461);
        end
        1: begin
          write_reg(wpf_pkg::REG_MAX_V, 21'd1000000);
          write_reg(wpf_pkg::REG_MAX_W, 21'd2000000);
          write_reg(wpf_pkg::REG_SLOW_W, 21'd2000000);
          write_reg(wpf_pkg::REG_REACH, 21'd65535);
          write_reg(wpf_pkg::REG_WINDOW, 21'd32767);
        end
        2: begin
          write_reg(wpf_pkg::REG_MAX_V, 21'd0); write_reg(wpf_pkg::REG_MAX_W, 21'd0);
          write_reg(wpf_pkg::REG_SLOW_W, 21'd0); write_reg(wpf_pkg::REG_WINDOW, 21'd1);
        end
        default: begin
          write_reg(wpf_pkg::REG_MAX_V, 21'($urandom_range(0, 1000000)));
          write_reg(wpf_pkg::REG_MAX_W, 21'($urandom_range(0, 2000000)));
          write_reg(wpf_pkg::REG_SLOW_W, 21'($urandom_range(0, 2000000)));
          write_reg(wpf_pkg::REG_REACH, 21'($urandom_range(0, 65535)));
          write_reg(wpf_pkg::REG_WINDOW, 21'($urandom_range(0, 32767)));
        end
      endcase
      if (ph == 1) hold_off = 1'b1;
      for (int i = 0; i < RandItems / 5; i++) rand_item(ph == 1 ? 2048 : 40);
      drain();
    end
    sending_done = 1'b1;
  end

  // receiver: random wait per transaction, one long hold-off
  initial begin
    int wait_n;
    logic held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      m_axis_tready = 1'b0;
      repeat (wait_n) @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    steer_t got, exp_r;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.sent = m_axis_tdata[2];
      got.speed = m_axis_tdata[22:3];
      got.turn = m_axis_tdata[44:23];
      got.changed = m_axis_tdata[45];
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = pending.pop_front();
        if (has_lit.pop_front()) exp_r = literal.pop_front();
        else void'(literal.pop_front());
        if (got.status != exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.sent != exp_r.sent) begin
          $error("cmd_sent exp %0d got %0d", exp_r.sent, got.sent); errors++;
        end
        if (got.speed != exp_r.speed) begin
          $error("speed_cmd exp %0d got %0d", exp_r.speed, got.speed); errors++;
        end
        if (got.turn != exp_r.turn) begin
          $error("turn_cmd exp %0d got %0d", $signed(exp_r.turn), $signed(got.turn));
          errors++;
        end
        if (got.changed != exp_r.changed) begin
          $error("path_changed exp %0d got %0d", exp_r.changed, got.changed); errors++;
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    if (errors == 0 && pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
